// ===== rtl/bbac_pkg.sv =====
// ---------------------------------------------------------------------------
// bbac_pkg
// Shared types and codes for the 3-D bounding box accumulator.
// ---------------------------------------------------------------------------
package bbac_pkg;

  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned RADIUS_W    = 31;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned IN_DATA_W   = 136;
  localparam int unsigned OUT_DATA_W  = 264;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;
  typedef logic [1:0]                relation_t;
  typedef logic [CFG_ADDR_W-1:0]     cfg_addr_t;

  localparam relation_t REL_OUTSIDE      = 2'd0;
  localparam relation_t REL_QUERY_INSIDE = 2'd1;
  localparam relation_t REL_INTERSECT    = 2'd2;

  localparam cfg_addr_t REG_QUERY_MIN_X = 3'd0;
  localparam cfg_addr_t REG_QUERY_MIN_Y = 3'd1;
  localparam cfg_addr_t REG_QUERY_MIN_Z = 3'd2;
  localparam cfg_addr_t REG_QUERY_MAX_X = 3'd3;
  localparam cfg_addr_t REG_QUERY_MAX_Y = 3'd4;
  localparam cfg_addr_t REG_QUERY_MAX_Z = 3'd5;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // Saturate a 33-bit signed sum back to the 32-bit coordinate range.
  function automatic coord_t sat_coord(input logic [COORD_W:0] sum);
    coord_t res;
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      res = sum[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      res = coord_t'(sum[COORD_W-1:0]);
    end
    return res;
  endfunction

endpackage

// ===== rtl/bounding_box_accumulate_classify_core.sv =====
// ---------------------------------------------------------------------------
// bounding_box_accumulate_classify_core
// Accumulates a 3-D axis-aligned bounding box from spheres and classifies it
// against a programmable query box.
// ---------------------------------------------------------------------------
// Takes one word per clock while the result side accepts results and returns one
// result word per input word. A word passes an input register, a stage that
// forms center -/+ radius with saturation, the box update stage (whose box
// registers carry the state from word to word) and the result register, in that
// order. Backpressure on the result side stalls only the stages that are full;
// empty stages keep taking words. Query registers are to be written only while
// the stream is idle; the block itself does not enforce this. Bounds, edges are
// Q16.16; an empty box reports zero bounds, zero edges and relation outside.
module bounding_box_accumulate_classify_core
  import bbac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]    cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // clear_box, include_point, point_x, point_y, point_z, sphere_radius, pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // low_x, low_y, low_z, high_x, high_y, high_z, is_empty, relation,
  // longest_edge, shortest_edge, pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // query registers
  coord_t q_lo_r [NUM_AXES];
  coord_t q_hi_r [NUM_AXES];

  // stage 1: input register
  logic    s1_valid_r;
  logic    s1_clear_r;
  logic    s1_incl_r;
  coord_t  s1_pt_r [NUM_AXES];
  radius_t s1_rad_r;

  // stage 2: sphere extent
  logic    s2_valid_r;
  logic    s2_clear_r;
  logic    s2_incl_r;
  coord_t  s2_lo_r [NUM_AXES];
  coord_t  s2_hi_r [NUM_AXES];

  // stage 3: box state
  logic    bx_valid_r;
  logic    bx_empty_r;
  logic    bx_empty_nxt;
  coord_t  bx_lo_r [NUM_AXES];
  coord_t  bx_hi_r [NUM_AXES];
  coord_t  bx_lo_nxt [NUM_AXES];
  coord_t  bx_hi_nxt [NUM_AXES];

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic en_out, en_bx, en_s2, en_s1;
  logic empty_eff;

  coord_t    ext_lo [NUM_AXES];
  coord_t    ext_hi [NUM_AXES];
  logic [COORD_W-1:0] ext_len [NUM_AXES];
  logic [COORD_W-1:0] longest, shortest;
  logic      q_inverted, disjoint, contains;
  relation_t relation;

  assign en_out    = !out_valid_r || out_tready;
  assign en_bx     = !bx_valid_r || en_out;
  assign en_s2     = !s2_valid_r || en_bx;
  assign en_s1     = !s1_valid_r || en_s2;
  assign in_tready = en_s1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        q_lo_r[a] <= '0;
        q_hi_r[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_QUERY_MIN_X: q_lo_r[0] <= coord_t'(cfg_wdata);
        REG_QUERY_MIN_Y: q_lo_r[1] <= coord_t'(cfg_wdata);
        REG_QUERY_MIN_Z: q_lo_r[2] <= coord_t'(cfg_wdata);
        REG_QUERY_MAX_X: q_hi_r[0] <= coord_t'(cfg_wdata);
        REG_QUERY_MAX_Y: q_hi_r[1] <= coord_t'(cfg_wdata);
        REG_QUERY_MAX_Z: q_hi_r[2] <= coord_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en_s1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1 && in_tvalid) begin
      s1_clear_r <= in_tdata[0];
      s1_incl_r  <= in_tdata[1];
      s1_pt_r[0] <= coord_t'(in_tdata[33:2]);
      s1_pt_r[1] <= coord_t'(in_tdata[65:34]);
      s1_pt_r[2] <= coord_t'(in_tdata[97:66]);
      s1_rad_r   <= in_tdata[128:98];
    end
  end

  // stage 2: center -/+ radius, saturated
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ext_lo[a] = sat_coord({s1_pt_r[a][COORD_W-1], s1_pt_r[a]} - {2'b00, s1_rad_r});
      ext_hi[a] = sat_coord({s1_pt_r[a][COORD_W-1], s1_pt_r[a]} + {2'b00, s1_rad_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2 && s1_valid_r) begin
      s2_clear_r <= s1_clear_r;
      s2_incl_r  <= s1_incl_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        s2_lo_r[a] <= ext_lo[a];
        s2_hi_r[a] <= ext_hi[a];
      end
    end
  end

  // stage 3: box update
  assign empty_eff = bx_empty_r || s2_clear_r;

  always_comb begin
    bx_empty_nxt = empty_eff && !s2_incl_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      bx_lo_nxt[a] = bx_lo_r[a];
      bx_hi_nxt[a] = bx_hi_r[a];
      if (s2_incl_r) begin
        if (empty_eff || (s2_lo_r[a] < bx_lo_r[a])) bx_lo_nxt[a] = s2_lo_r[a];
        if (empty_eff || (s2_hi_r[a] > bx_hi_r[a])) bx_hi_nxt[a] = s2_hi_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_valid_r <= 1'b0;
      bx_empty_r <= 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        bx_lo_r[a] <= '0;
        bx_hi_r[a] <= '0;
      end
    end else if (en_bx) begin
      bx_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        bx_empty_r <= bx_empty_nxt;
        for (int a = 0; a < NUM_AXES; a++) begin
          bx_lo_r[a] <= bx_lo_nxt[a];
          bx_hi_r[a] <= bx_hi_nxt[a];
        end
      end
    end
  end

  // result: edges and query relation
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ext_len[a] = bx_hi_r[a] - bx_lo_r[a];
    end
    longest  = ext_len[0];
    shortest = ext_len[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (ext_len[a] > longest)  longest  = ext_len[a];
      if (ext_len[a] < shortest) shortest = ext_len[a];
    end

    q_inverted = 1'b0;
    disjoint   = 1'b0;
    contains   = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (q_lo_r[a] > q_hi_r[a]) q_inverted = 1'b1;
      if ((bx_hi_r[a] < q_lo_r[a]) || (bx_lo_r[a] > q_hi_r[a])) disjoint = 1'b1;
      if (!((bx_lo_r[a] <= q_lo_r[a]) && (bx_hi_r[a] >= q_hi_r[a]))) contains = 1'b0;
    end

    priority if (bx_empty_r || q_inverted || disjoint) begin
      relation = REL_OUTSIDE;
    end else if (contains) begin
      relation = REL_QUERY_INSIDE;
    end else begin
      relation = REL_INTERSECT;
    end

    out_data_nxt = '0;
    if (!bx_empty_r) begin
      out_data_nxt[31:0]    = bx_lo_r[0];
      out_data_nxt[63:32]   = bx_lo_r[1];
      out_data_nxt[95:64]   = bx_lo_r[2];
      out_data_nxt[127:96]  = bx_hi_r[0];
      out_data_nxt[159:128] = bx_hi_r[1];
      out_data_nxt[191:160] = bx_hi_r[2];
      out_data_nxt[226:195] = longest;
      out_data_nxt[258:227] = shortest;
    end
    out_data_nxt[192]     = bx_empty_r;
    out_data_nxt[194:193] = relation;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= bx_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && bx_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[192] |->
      (out_tdata[191:0] == '0) && (out_tdata[258:195] == '0) &&
      (out_tdata[194:193] == REL_OUTSIDE))
    else $error("empty box result carries nonzero bounds or relation");

  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[192] |-> out_tdata[226:195] >= out_tdata[258:227])
    else $error("longest edge below shortest edge");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !bx_empty_r |-> (bx_hi_r[0] >= bx_lo_r[0]) && (bx_hi_r[1] >= bx_lo_r[1]) &&
                    (bx_hi_r[2] >= bx_lo_r[2]))
    else $error("box upper bound below lower bound");

  a_include_fills: assert property (@(posedge clk) disable iff (!rst_n)
    en_bx && s2_valid_r && s2_incl_r |=> !bx_empty_r)
    else $error("box still empty after an extend");

endmodule
